[hdl/tpdt_pkg.sv]
package tpdt_pkg;

  // Item kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    FUNC_PIN_CHANGE = 2'd0,
    FUNC_TICK       = 2'd1,
    FUNC_DISP_START = 2'd2,
    FUNC_CAPTURE    = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_LIMIT = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_DISPLAY_LIMIT  = 1'b1;

  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned DebCountWidth = 8;
  localparam int unsigned DspCountWidth = 16;

  localparam logic [DebCountWidth-1:0] DebLimitReset = 8'd3;
  localparam logic [DspCountWidth-1:0] DspLimitReset = 16'd500;

  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 8;

  // One input item as held in the input register.
  typedef struct packed {
    func_e func;
    logic  clear_display_count;
    logic  reed_level;
    logic  button_level;
  } item_t;

  // One result item, packed so that the last field lands in bit zero.
  typedef struct packed {
    logic ticking;
    logic display_off;
    logic reed_open;
    logic reed_close;
    logic button_release;
    logic button_press;
  } result_t;

endpackage

[hdl/tpdt_in_stage.sv]
module tpdt_in_stage
  import tpdt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  advance_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // The register takes a new item when empty or when its item moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hdl/tpdt_core.sv]
module tpdt_core
  import tpdt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     item_en_i,
  input  item_t                    item_i,
  output result_t                  result_o
);

  logic [DebCountWidth-1:0] deb_limit_q, deb_limit_d;
  logic [DspCountWidth-1:0] dsp_limit_q, dsp_limit_d;

  logic btn_stable_q, btn_stable_d;
  logic reed_stable_q, reed_stable_d;
  logic btn_pend_q, btn_pend_d;
  logic reed_pend_q, reed_pend_d;
  logic deb_active_q, deb_active_d;
  logic dsp_active_q, dsp_active_d;
  logic [DebCountWidth-1:0] deb_count_q, deb_count_d;
  logic [DspCountWidth-1:0] dsp_count_q, dsp_count_d;

  logic [DebCountWidth-1:0] deb_inc;
  logic [DspCountWidth-1:0] dsp_inc;
  result_t res;

  // Configuration writes; an index beyond the list is dropped.
  always_comb begin
    deb_limit_d = deb_limit_q;
    dsp_limit_d = dsp_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_LIMIT: deb_limit_d = cfg_data_i[DebCountWidth-1:0];
        CFG_DISPLAY_LIMIT:  dsp_limit_d = cfg_data_i[DspCountWidth-1:0];
        default: ;
      endcase
    end
  end

  assign deb_inc = deb_count_q + DebCountWidth'(1);
  assign dsp_inc = dsp_count_q + DspCountWidth'(1);

  // Per-item update of the pin flags and both timers.
  always_comb begin
    btn_stable_d  = btn_stable_q;
    reed_stable_d = reed_stable_q;
    btn_pend_d    = btn_pend_q;
    reed_pend_d   = reed_pend_q;
    deb_active_d  = deb_active_q;
    dsp_active_d  = dsp_active_q;
    deb_count_d   = deb_count_q;
    dsp_count_d   = dsp_count_q;
    res           = '0;
    if (item_en_i) begin
      unique case (item_i.func)
        FUNC_PIN_CHANGE: begin
          if (item_i.button_level != btn_stable_q) btn_pend_d = 1'b1;
          if (item_i.reed_level != reed_stable_q) reed_pend_d = 1'b1;
          deb_active_d = 1'b1;
        end
        FUNC_TICK: begin
          if (deb_active_q) begin
            deb_count_d = deb_inc;
            if (deb_inc >= deb_limit_q) begin
              // Debounce period over: resample each pending pin.
              deb_count_d  = '0;
              deb_active_d = 1'b0;
              if (btn_pend_q) begin
                res.button_release = item_i.button_level;
                res.button_press   = !item_i.button_level;
                btn_pend_d         = 1'b0;
                btn_stable_d       = item_i.button_level;
              end
              if (reed_pend_q) begin
                res.reed_open  = item_i.reed_level;
                res.reed_close = !item_i.reed_level;
                reed_pend_d    = 1'b0;
                reed_stable_d  = item_i.reed_level;
              end
            end
          end
          if (dsp_active_q) begin
            dsp_count_d = dsp_inc;
            if (dsp_inc >= dsp_limit_q) begin
              res.display_off = 1'b1;
              dsp_count_d     = '0;
              dsp_active_d    = 1'b0;
            end
          end
        end
        FUNC_DISP_START: begin
          if (item_i.clear_display_count) dsp_count_d = '0;
          dsp_active_d = 1'b1;
        end
        FUNC_CAPTURE: begin
          btn_stable_d  = item_i.button_level;
          reed_stable_d = item_i.reed_level;
        end
        default: ;
      endcase
    end
    res.ticking = deb_active_d | dsp_active_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q   <= DebLimitReset;
      dsp_limit_q   <= DspLimitReset;
      btn_stable_q  <= 1'b1;
      reed_stable_q <= 1'b1;
      btn_pend_q    <= 1'b0;
      reed_pend_q   <= 1'b0;
      deb_active_q  <= 1'b0;
      dsp_active_q  <= 1'b0;
      deb_count_q   <= '0;
      dsp_count_q   <= '0;
    end else begin
      deb_limit_q   <= deb_limit_d;
      dsp_limit_q   <= dsp_limit_d;
      btn_stable_q  <= btn_stable_d;
      reed_stable_q <= reed_stable_d;
      btn_pend_q    <= btn_pend_d;
      reed_pend_q   <= reed_pend_d;
      deb_active_q  <= deb_active_d;
      dsp_active_q  <= dsp_active_d;
      deb_count_q   <= deb_count_d;
      dsp_count_q   <= dsp_count_d;
    end
  end

  // An idle debounce timer always has a cleared count.
  a_deb_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !deb_active_q |-> deb_count_q == '0)
    else $error("debounce count nonzero while timer idle");

  // An idle display timer always has a cleared count.
  a_dsp_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dsp_active_q |-> dsp_count_q == '0)
    else $error("display count nonzero while timer idle");

  // A pending pin always has the debounce timer running.
  a_pend_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (btn_pend_q || reed_pend_q) |-> deb_active_q)
    else $error("pin pending without debounce timer");

  // Events come only from tick items.
  a_events_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_en_i && item_i.func != FUNC_TICK) |->
      !(res.button_press || res.button_release || res.reed_close ||
        res.reed_open || res.display_off))
    else $error("event raised by a non-tick item");

endmodule

[hdl/two_pin_debounce_and_display_timeout.sv]
// Two-pin debouncer with display-off timeout.
//
// Input channel (s_axis_*): one item per handshake. tuser carries the item
// kind (pin change, tick, display start, idle-level capture) and tdata the
// current button and reed pin levels plus the display count clear flag.
// Output channel (m_axis_*): exactly one result item per input item, in
// order, with the press, release, close, open, display-off and ticking bits.
// Configuration channel (cfg_*): index 0 writes the debounce limit, index 1
// the display timeout limit; it is always ready and must only be used while
// the block is idle.
// From the input handshake an item passes through the input register, then
// through the combinational state update into the result register.
// Throughput is one item per cycle while the receiver takes results, set by
// the combinational state update loop.
// Reset clears both registers' valid flags, sets both stable levels to one,
// clears pending flags and timers and loads the default limits.
// When the receiver stalls, the result register holds its item; an empty
// input register still takes one more item, and then s_axis_tready_o drops.
module two_pin_debounce_and_display_timeout
  import tpdt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [0] button_level, [1] reed_level, [2] clear_display_count, rest zero
  input  logic [InDataWidth-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]               s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [0] button_press, [1] button_release, [2] reed_close, [3] reed_open,
  // [4] display_off, [5] ticking, rest zero
  output logic [OutDataWidth-1:0]  m_axis_tdata_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Unpack the input item.
  assign in_item.func                = func_e'(s_axis_tuser_i);
  assign in_item.clear_display_count = s_axis_tdata_i[2];
  assign in_item.reed_level          = s_axis_tdata_i[1];
  assign in_item.button_level        = s_axis_tdata_i[0];

  // The held item moves on when the result register is free or draining.
  assign advance     = item_valid && (!out_valid_q || m_axis_tready_i);
  assign cfg_ready_o = 1'b1;

  tpdt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tpdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_en_i   (advance),
    .item_i      (item),
    .result_o    (result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataWidth - $bits(result_t)){1'b0}}, out_q};

endmodule
